@@ rtl/core/tga_uncompressed_stream_decoder_top_defines.svh @@
// Assertion macros shared by the TGA stream decoder modules.
// Expects clk and arst_n in scope at the point of use.
`ifndef TGA_UNCOMPRESSED_STREAM_DECODER_TOP_DEFINES_SVH
`define TGA_UNCOMPRESSED_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define TGA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tga_usd_pkg.sv @@
// Shared types and constants for the TGA uncompressed stream decoder.
// No dependencies.
`default_nettype none
package tga_usd_pkg;

	localparam int HdrLen   = 12;
	localparam int InfoEnd  = 18;
	localparam int BppRgb   = 24;
	localparam int BppRgba  = 32;

	// parse phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_INFO   = 3'd2;
	localparam logic [2:0] PH_PIXELS = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// result status codes
	localparam logic [2:0] ST_PIXEL      = 3'd0;
	localparam logic [2:0] ST_HEADER_OK  = 3'd1;
	localparam logic [2:0] ST_BAD_HEADER = 3'd2;
	localparam logic [2:0] ST_BAD_INFO   = 3'd3;
	localparam logic [2:0] ST_TRUNCATED  = 3'd4;

	// fixed uncompressed-truecolour header
	function automatic logic [7:0] hdr_byte(input logic [3:0] idx);
		logic [7:0] b;
		b = 8'd0;
		if (idx == 4'd2) begin
			b = 8'd2;
		end
		return b;
	endfunction

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        has_alpha;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        last_pixel;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/core/tga_usd_parse.sv @@
// Byte parser: header check, info capture, pixel assembly and position count.
// Depends on tga_usd_pkg and the assertion macro header.
`default_nettype none
`include "tga_uncompressed_stream_decoder_top_defines.svh"
module tga_usd_parse (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_take,
	input  wire logic [7:0]        data_byte,
	input  wire logic              file_start,
	input  wire logic              stream_end,
	output logic                   res_valid,
	output tga_usd_pkg::res_t      res
);

	logic [2:0]       phase_q, phase_d;
	logic [4:0]       hpos_q, hpos_d;
	logic             mism_q, mism_d;
	logic [15:0]      width_q, width_d;
	logic [15:0]      height_q, height_d;
	logic             amode_q, amode_d;
	logic [15:0]      col_q, col_d;
	logic [15:0]      row_q, row_d;
	logic [1:0]       pbi_q, pbi_d;
	logic [2:0][7:0]  held_q, held_d;

	logic [2:0]       st;
	logic [7:0]       r, g, b, a;
	logic             lst;
	logic [2:0]       info_idx;
	logic [1:0]       pbi_top;
	logic [15:0]      w_m1, h_m1;

	always_comb begin
		phase_d  = phase_q;
		hpos_d   = hpos_q;
		mism_d   = mism_q;
		width_d  = width_q;
		height_d = height_q;
		amode_d  = amode_q;
		col_d    = col_q;
		row_d    = row_q;
		pbi_d    = pbi_q;
		held_d   = held_q;
		res_valid = 1'b0;
		st  = tga_usd_pkg::ST_PIXEL;
		r   = 8'd0;
		g   = 8'd0;
		b   = 8'd0;
		a   = 8'd0;
		lst = 1'b0;
		info_idx = 3'd0;
		pbi_top  = 2'd0;
		w_m1 = 16'd0;
		h_m1 = 16'd0;

		if (in_take) begin
			if (file_start) begin
				phase_d  = tga_usd_pkg::PH_HEADER;
				hpos_d   = 5'd0;
				mism_d   = 1'b0;
				width_d  = 16'd0;
				height_d = 16'd0;
				amode_d  = 1'b0;
				col_d    = 16'd0;
				row_d    = 16'd0;
				pbi_d    = 2'd0;
				held_d   = '0;
			end

			unique case (phase_d)
				tga_usd_pkg::PH_HEADER: begin
					if (hpos_d < 5'(tga_usd_pkg::HdrLen) &&
					    data_byte != tga_usd_pkg::hdr_byte(hpos_d[3:0])) begin
						mism_d = 1'b1;
					end
					hpos_d = hpos_d + 5'd1;
					if (hpos_d >= 5'(tga_usd_pkg::HdrLen)) begin
						hpos_d = 5'(tga_usd_pkg::HdrLen);
						if (mism_d) begin
							res_valid = 1'b1;
							st = tga_usd_pkg::ST_BAD_HEADER;
							phase_d = tga_usd_pkg::PH_DONE;
						end else begin
							phase_d = tga_usd_pkg::PH_INFO;
						end
					end
					if (!res_valid && stream_end) begin
						res_valid = 1'b1;
						st = tga_usd_pkg::ST_TRUNCATED;
						phase_d = tga_usd_pkg::PH_DONE;
					end
				end
				tga_usd_pkg::PH_INFO: begin
					info_idx = 3'(hpos_d - 5'(tga_usd_pkg::HdrLen));
					unique case (info_idx)
						3'd0: width_d  = {8'd0, data_byte};
						3'd1: width_d  = {data_byte, width_d[7:0]};
						3'd2: height_d = {8'd0, data_byte};
						3'd3: height_d = {data_byte, height_d[7:0]};
						3'd4: begin
							amode_d = (data_byte == 8'(tga_usd_pkg::BppRgba));
							mism_d  = (data_byte != 8'(tga_usd_pkg::BppRgb)) &&
							          (data_byte != 8'(tga_usd_pkg::BppRgba));
						end
						default: ;
					endcase
					hpos_d = hpos_d + 5'd1;
					if (hpos_d >= 5'(tga_usd_pkg::InfoEnd)) begin
						hpos_d = 5'(tga_usd_pkg::InfoEnd);
						res_valid = 1'b1;
						if (mism_d || width_d == 16'd0 || height_d == 16'd0) begin
							st = tga_usd_pkg::ST_BAD_INFO;
							phase_d = tga_usd_pkg::PH_DONE;
						end else if (stream_end) begin
							st = tga_usd_pkg::ST_TRUNCATED;
							phase_d = tga_usd_pkg::PH_DONE;
						end else begin
							st = tga_usd_pkg::ST_HEADER_OK;
							phase_d = tga_usd_pkg::PH_PIXELS;
							col_d = 16'd0;
							row_d = 16'd0;
							pbi_d = 2'd0;
						end
					end else if (stream_end) begin
						res_valid = 1'b1;
						st = tga_usd_pkg::ST_TRUNCATED;
						phase_d = tga_usd_pkg::PH_DONE;
					end
				end
				tga_usd_pkg::PH_PIXELS: begin
					pbi_top = amode_d ? 2'd3 : 2'd2;
					if (pbi_d < pbi_top) begin
						if (pbi_d != 2'd3) begin
							held_d[pbi_d] = data_byte;
						end
						pbi_d = pbi_d + 2'd1;
						if (stream_end) begin
							res_valid = 1'b1;
							st = tga_usd_pkg::ST_TRUNCATED;
							phase_d = tga_usd_pkg::PH_DONE;
						end
					end else begin
						pbi_d = 2'd0;
						w_m1 = width_d - 16'd1;
						h_m1 = height_d - 16'd1;
						res_valid = 1'b1;
						if (col_d == w_m1 && row_d == h_m1) begin
							phase_d = tga_usd_pkg::PH_DONE;
							lst = 1'b1;
						end else if (stream_end) begin
							st = tga_usd_pkg::ST_TRUNCATED;
							phase_d = tga_usd_pkg::PH_DONE;
						end else if (col_d >= w_m1) begin
							col_d = 16'd0;
							row_d = row_d + 16'd1;
						end else begin
							col_d = col_d + 16'd1;
						end
						if (st == tga_usd_pkg::ST_PIXEL) begin
							b = held_d[0];
							g = held_d[1];
							r = amode_d ? held_d[2] : data_byte;
							a = amode_d ? data_byte : 8'd0;
						end
					end
				end
				default: ;
			endcase
		end

		res.status       = st;
		res.red          = r;
		res.green        = g;
		res.blue         = b;
		res.alpha        = a;
		res.has_alpha    = amode_d;
		res.image_width  = width_d;
		res.image_height = height_d;
		res.last_pixel   = lst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tga_usd_pkg::PH_IDLE;
			hpos_q   <= 5'd0;
			mism_q   <= 1'b0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			amode_q  <= 1'b0;
			col_q    <= 16'd0;
			row_q    <= 16'd0;
			pbi_q    <= 2'd0;
			held_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			hpos_q   <= hpos_d;
			mism_q   <= mism_d;
			width_q  <= width_d;
			height_q <= height_d;
			amode_q  <= amode_d;
			col_q    <= col_d;
			row_q    <= row_d;
			pbi_q    <= pbi_d;
			held_q   <= held_d;
		end
	end

	`TGA_ASSERT_NOW(a_hpos_range, 1'b1, hpos_q <= 5'(tga_usd_pkg::InfoEnd), "header position overran")
	`TGA_ASSERT_NOW(a_pix_dims, phase_q == tga_usd_pkg::PH_PIXELS, width_q != 16'd0 && height_q != 16'd0 && hpos_q == 5'(tga_usd_pkg::InfoEnd), "pixel phase without valid info")
	`TGA_ASSERT_NOW(a_pix_pos, phase_q == tga_usd_pkg::PH_PIXELS, col_q < width_q && row_q < height_q, "pixel position outside image")

endmodule
`default_nettype wire

@@ rtl/core/tga_usd_oreg.sv @@
// Result register with a skid stage so the input side runs while output stalls.
// Depends on tga_usd_pkg and the assertion macro header.
`default_nettype none
`include "tga_uncompressed_stream_decoder_top_defines.svh"
module tga_usd_oreg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tga_usd_pkg::res_t push_res,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tga_usd_pkg::res_t      out_res
);

	logic               main_v_q, skid_v_q;
	tga_usd_pkg::res_t  main_q, skid_q;
	logic               pop;

	assign pop       = main_v_q && out_ready;
	assign room      = !skid_v_q;
	assign out_valid = main_v_q;
	assign out_res   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !main_v_q) begin
			if (skid_v_q) begin
				main_v_q <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (pop || !main_v_q) begin
			main_q <= skid_v_q ? skid_q : push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	`TGA_ASSERT_NOW(a_skid_main, skid_v_q, main_v_q, "skid beat held with empty output register")
	`TGA_ASSERT_NOW(a_no_push_full, skid_v_q, !push, "beat pushed into full buffer")
	`TGA_ASSERT_NOW(a_last_is_pixel, main_v_q && main_q.last_pixel, main_q.status == tga_usd_pkg::ST_PIXEL, "last flag on non-pixel beat")

endmodule
`default_nettype wire

@@ rtl/core/tga_uncompressed_stream_decoder_top.sv @@
// Top level of the uncompressed true-colour TGA stream decoder.
// Depends on tga_usd_pkg, tga_usd_parse and tga_usd_oreg.
//
//  Channel  | Dir | tdata                         | tuser      | tlast
//  s_axis   | in  | data_byte                     | file_start | stream_end
//  m_axis   | out | pixel, alpha flag, dimensions | status     | last_pixel
//
// One byte beat per cycle while s_axis_tready is high; a result is registered
// at the edge that takes its byte, into the skid stage if m_axis is stalled.
// s_axis_tready drops only while output register and skid stage both hold a
// beat, i.e. with two results waiting on m_axis_tready.
// Reset leaves the parser idle until a file_start beat; bytes before that,
// or after completion or an error, give no result.
`default_nettype none
module tga_uncompressed_stream_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] file_start
	input  wire logic        s_axis_tlast,   // stream_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] has_alpha,
	// [48:33] image_width, [64:49] image_height, [71:65] zero
	output logic [71:0]      m_axis_tdata,
	output logic [2:0]       m_axis_tuser,   // [2:0] status
	output logic             m_axis_tlast    // last_pixel
);

	logic               take;
	logic               room;
	logic               res_valid;
	tga_usd_pkg::res_t  res;
	tga_usd_pkg::res_t  out_res;

	assign s_axis_tready = room;
	assign take          = s_axis_tvalid && room;

	tga_usd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_take    (take),
		.data_byte  (s_axis_tdata),
		.file_start (s_axis_tuser),
		.stream_end (s_axis_tlast),
		.res_valid  (res_valid),
		.res        (res)
	);

	tga_usd_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// pack beat fields, red in the lowest bits
	assign m_axis_tdata = {7'd0, out_res.image_height, out_res.image_width,
	                       out_res.has_alpha, out_res.alpha, out_res.blue,
	                       out_res.green, out_res.red};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last_pixel;

endmodule
`default_nettype wire

@@ test/tb_tga_uncompressed_stream_decoder_top.sv @@
// Self-checking bench for the TGA stream decoder: feeds whole TGA byte streams,
// predicts each header/pixel/error beat and compares it against m_axis.
// Depends on tga_usd_pkg and tga_uncompressed_stream_decoder_top.
module tb_tga_uncompressed_stream_decoder_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit   = 5000;
	localparam int RandomBytes = 260;
	localparam int GapPerMode  = 90;
	// fixed uncompressed-truecolour signature, byte 0 in the lowest bits
	localparam logic [95:0] TgaSig = 96'h0000_0000_0000_0000_0002_0000;

	typedef struct {
		logic [7:0] data;
		logic       start;
		logic       eos;
		logic       hold;   // wait for every pending result before this beat
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
	logic        s_axis_tuser = 1'b0;   // [0] file_start
	logic        s_axis_tlast = 1'b0;   // stream_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [32] has_alpha,
	// [48:33] image_width, [64:49] image_height
	logic [71:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;          // [2:0] status
	logic        m_axis_tlast;          // last_pixel

	tga_uncompressed_stream_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #1 clk = ~clk;

	beat_t              byte_q[$];
	tga_usd_pkg::res_t  decoded_q[$];
	beat_t              cur_beat;
	tga_usd_pkg::res_t  want;
	int                 stim_bytes = 0;
	int                 bytes_in = 0;
	int                 err_cnt = 0;
	int                 idle_cycles = 0;
	int unsigned        send_gap_pct = 0;
	int unsigned        recv_stall_pct = 0;

	// decoder image of the block
	logic [2:0]  ph;
	logic [4:0]  hpos;
	logic        hbad;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic        alpha_on;
	logic [15:0] col;
	logic [15:0] row;
	int unsigned pix_idx;
	logic [7:0]  held [3];

	task automatic clear_parser();
		hpos = '0;
		hbad = 1'b0;
		img_w = '0;
		img_h = '0;
		alpha_on = 1'b0;
		col = '0;
		row = '0;
		pix_idx = 0;
		for (int i = 0; i < 3; i++) held[i] = 8'd0;
	endtask

	task automatic post_result(input logic [2:0] st, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic [7:0] a, input logic last);
		tga_usd_pkg::res_t x;
		x.status       = st;
		x.red          = r;
		x.green        = g;
		x.blue         = b;
		x.alpha        = a;
		x.has_alpha    = alpha_on;
		x.image_width  = img_w;
		x.image_height = img_h;
		x.last_pixel   = last;
		decoded_q.push_back(x);
	endtask

	task automatic abort_file(input logic [2:0] st);
		ph = tga_usd_pkg::PH_DONE;
		post_result(st, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
	endtask

	// one accepted byte through the parser
	task automatic decode_byte(input beat_t bt);
		int          k;
		int unsigned px_bytes;
		logic [7:0]  r, g, b, a;
		if (bt.start) begin
			clear_parser();
			ph = tga_usd_pkg::PH_HEADER;
		end
		case (ph)
			tga_usd_pkg::PH_HEADER: begin
				if (hpos < tga_usd_pkg::HdrLen && bt.data != TgaSig[hpos*8 +: 8]) hbad = 1'b1;
				hpos++;
				if (hpos >= tga_usd_pkg::HdrLen) begin
					hpos = 5'(tga_usd_pkg::HdrLen);
					if (hbad) begin
						abort_file(tga_usd_pkg::ST_BAD_HEADER);
						return;
					end
					ph = tga_usd_pkg::PH_INFO;
				end
				if (bt.eos) abort_file(tga_usd_pkg::ST_TRUNCATED);
			end
			tga_usd_pkg::PH_INFO: begin
				k = int'(hpos) - tga_usd_pkg::HdrLen;
				case (k)
					0: img_w = {8'd0, bt.data};
					1: img_w[15:8] = bt.data;
					2: img_h = {8'd0, bt.data};
					3: img_h[15:8] = bt.data;
					4: begin
						alpha_on = (bt.data == 8'(tga_usd_pkg::BppRgba));
						hbad = !(bt.data == 8'(tga_usd_pkg::BppRgb) ||
						         bt.data == 8'(tga_usd_pkg::BppRgba));
					end
					default: ;
				endcase
				hpos++;
				if (hpos >= tga_usd_pkg::InfoEnd) begin
					hpos = 5'(tga_usd_pkg::InfoEnd);
					if (hbad || img_w == 16'd0 || img_h == 16'd0) begin
						abort_file(tga_usd_pkg::ST_BAD_INFO);
					end else if (bt.eos) begin
						abort_file(tga_usd_pkg::ST_TRUNCATED);
					end else begin
						ph = tga_usd_pkg::PH_PIXELS;
						col = '0;
						row = '0;
						pix_idx = 0;
						post_result(tga_usd_pkg::ST_HEADER_OK, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
					end
				end else if (bt.eos) begin
					abort_file(tga_usd_pkg::ST_TRUNCATED);
				end
			end
			tga_usd_pkg::PH_PIXELS: begin
				px_bytes = alpha_on ? 4 : 3;
				if (pix_idx + 1 < px_bytes) begin
					if (pix_idx < 3) held[pix_idx] = bt.data;
					pix_idx++;
					if (bt.eos) abort_file(tga_usd_pkg::ST_TRUNCATED);
				end else begin
					// stored order is B, G, R(, A)
					pix_idx = 0;
					b = held[0];
					g = held[1];
					if (alpha_on) begin
						r = held[2];
						a = bt.data;
					end else begin
						r = bt.data;
						a = 8'd0;
					end
					if (col == img_w - 16'd1 && row == img_h - 16'd1) begin
						// final pixel wins over stream_end
						ph = tga_usd_pkg::PH_DONE;
						post_result(tga_usd_pkg::ST_PIXEL, r, g, b, a, 1'b1);
					end else if (bt.eos) begin
						abort_file(tga_usd_pkg::ST_TRUNCATED);
					end else begin
						if (col >= img_w - 16'd1) begin
							col = '0;
							row = row + 16'd1;
						end else begin
							col = col + 16'd1;
						end
						post_result(tga_usd_pkg::ST_PIXEL, r, g, b, a, 1'b0);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] d, input logic st, input logic e, input logic h);
		beat_t bt;
		bt.data  = d;
		bt.start = st;
		bt.eos   = e;
		bt.hold  = h;
		byte_q.push_back(bt);
		stim_bytes++;
	endtask

	// One TGA file. bad_pos >= 0 corrupts that signature byte; cut > 0 stops after
	// cut bytes (stream_end on the last one if cut_end); junk trails the file.
	task automatic queue_file(input int w, input int h, input int bpp, input int bad_pos,
			input int cut, input bit cut_end, input int junk, input bit hold);
		longint     total;
		int         px;
		logic [7:0] d;
		logic       e;
		px = (bpp == tga_usd_pkg::BppRgba) ? 4 : 3;
		if (w == 0 || h == 0 || !(bpp == tga_usd_pkg::BppRgb || bpp == tga_usd_pkg::BppRgba)
				|| bad_pos >= 0)
			total = longint'(tga_usd_pkg::InfoEnd);
		else
			total = longint'(tga_usd_pkg::InfoEnd) + longint'(w) * h * px;
		if (cut > 0) total = longint'(cut);
		for (int i = 0; i < total; i++) begin
			case (i)
				12: d = w[7:0];
				13: d = w[15:8];
				14: d = h[7:0];
				15: d = h[15:8];
				16: d = bpp[7:0];
				default: d = (i < tga_usd_pkg::HdrLen) ? TgaSig[i*8 +: 8] :
					8'($urandom_range(0, 255));
			endcase
			if (i == bad_pos) d = d ^ 8'($urandom_range(1, 255));
			e = (i == total - 1) && ((cut > 0) ? cut_end : ($urandom_range(0, 3) == 0));
			queue_byte(d, i == 0, e, hold && i == 0);
		end
		repeat (junk) queue_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
			1'b0);
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	// Driver: one beat held on s_axis until taken; idling set by the phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'd0;
			s_axis_tuser  <= 1'b0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				decode_byte(cur_beat);
				bytes_in++;
			end
			case ((bytes_in / GapPerMode) % 4)
				0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_gap_pct = 51; recv_stall_pct = 0;  end
				2: begin send_gap_pct = 0;  recv_stall_pct = 51; end
				default: begin send_gap_pct = 16; recv_stall_pct = 16; end
			endcase
			if (!s_axis_tvalid || s_axis_tready) begin
				if (byte_q.size() != 0 && !(byte_q[0].hold && decoded_q.size() != 0)
						&& $urandom_range(0, 99) >= send_gap_pct) begin
					cur_beat = byte_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= cur_beat.data;
					s_axis_tuser  <= cur_beat.start;
					s_axis_tlast  <= cur_beat.eos;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Monitor: every result beat against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				$error("result beat with nothing expected, status %0d", m_axis_tuser);
				err_cnt++;
			end else begin
				want = decoded_q.pop_front();
				check_field("status", 32'(want.status), 32'(m_axis_tuser));
				check_field("red", 32'(want.red), 32'(m_axis_tdata[7:0]));
				check_field("green", 32'(want.green), 32'(m_axis_tdata[15:8]));
				check_field("blue", 32'(want.blue), 32'(m_axis_tdata[23:16]));
				check_field("alpha", 32'(want.alpha), 32'(m_axis_tdata[31:24]));
				check_field("has_alpha", 32'(want.has_alpha), 32'(m_axis_tdata[32]));
				check_field("image_width", 32'(want.image_width), 32'(m_axis_tdata[48:33]));
				check_field("image_height", 32'(want.image_height),
					32'(m_axis_tdata[64:49]));
				check_field("last_pixel", 32'(want.last_pixel), 32'(m_axis_tlast));
			end
		end
	end

	// Watchdog on beats moving through either port.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IdleLimit) begin
				$error("no beat accepted for %0d cycles", IdleLimit);
				$display("tb_tga_uncompressed_stream_decoder_top: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int w, h, bpp, pick, rand_start, nfile;
		bit hold;
		clear_parser();
		ph = tga_usd_pkg::PH_IDLE;

		// bytes before any file start are dropped
		queue_byte(8'hA5, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b1, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		// clean images, 24 and 32 bit, trailing bytes after completion
		queue_file(2, 2, tga_usd_pkg::BppRgb, -1, 0, 1'b0, 0, 1'b0);
		queue_file(3, 1, tga_usd_pkg::BppRgba, -1, 0, 1'b0, 3, 1'b0);
		queue_file(1, 1, tga_usd_pkg::BppRgb, -1, 0, 1'b0, 0, 1'b1);
		// bad signature; on the twelfth byte it beats stream_end
		queue_file(1, 1, tga_usd_pkg::BppRgb, 2, tga_usd_pkg::HdrLen, 1'b1, 0, 1'b0);
		queue_file(1, 1, tga_usd_pkg::BppRgb, 0, 0, 1'b0, 0, 1'b0);
		queue_file(1, 1, tga_usd_pkg::BppRgb, tga_usd_pkg::HdrLen - 1, 0, 1'b0, 0, 1'b0);
		// bad info: zero width (with stream_end), zero height, odd depths
		queue_file(0, 1, tga_usd_pkg::BppRgb, -1, tga_usd_pkg::InfoEnd, 1'b1, 0, 1'b0);
		queue_file(5, 0, tga_usd_pkg::BppRgba, -1, 0, 1'b0, 0, 1'b0);
		queue_file(1, 1, 8, -1, 0, 1'b0, 0, 1'b0);
		queue_file(2, 2, 255, -1, 0, 1'b0, 0, 1'b0);
		// early end: last info byte, mid header, mid info, mid pixel, non-final pixel
		queue_file(1, 1, tga_usd_pkg::BppRgba, -1, tga_usd_pkg::InfoEnd, 1'b1, 0, 1'b0);
		queue_file(1, 1, tga_usd_pkg::BppRgb, -1, 5, 1'b1, 0, 1'b0);
		queue_file(1, 1, tga_usd_pkg::BppRgb, -1, 14, 1'b1, 0, 1'b0);
		queue_file(2, 1, tga_usd_pkg::BppRgba, -1, tga_usd_pkg::InfoEnd + 2, 1'b1, 0, 1'b0);
		queue_file(2, 1, tga_usd_pkg::BppRgb, -1, tga_usd_pkg::InfoEnd + 3, 1'b1, 0, 1'b0);
		// largest dimensions, cut short
		queue_file(65535, 65535, tga_usd_pkg::BppRgba, -1, tga_usd_pkg::InfoEnd + 9, 1'b1,
			0, 1'b0);
		queue_file(65535, 1, tga_usd_pkg::BppRgb, -1, tga_usd_pkg::InfoEnd + 6, 1'b1, 0, 1'b0);
		// new file start in the middle of the pixels
		queue_file(3, 2, tga_usd_pkg::BppRgb, -1, 25, 1'b0, 0, 1'b0);
		queue_file(1, 2, tga_usd_pkg::BppRgba, -1, 0, 1'b0, 1, 1'b0);

		// random part: mostly well-formed small images
		rand_start = stim_bytes;
		nfile = 0;
		while (stim_bytes - rand_start < RandomBytes) begin
			pick = $urandom_range(0, 99);
			hold = (nfile % 6 == 5);
			nfile++;
			w = $urandom_range(1, 4);
			h = $urandom_range(1, 3);
			bpp = $urandom_range(0, 1) ? tga_usd_pkg::BppRgba : tga_usd_pkg::BppRgb;
			if (pick < 65) begin
				queue_file(w, h, bpp, -1, 0, 1'b0, $urandom_range(0, 2), hold);
			end else if (pick < 77) begin
				queue_file(w, h, bpp, -1,
					$urandom_range(1, tga_usd_pkg::InfoEnd + w * h * (bpp / 8) - 1),
					1'($urandom_range(0, 1)), 0, hold);
			end else if (pick < 85) begin
				queue_file(w, h, bpp, $urandom_range(0, tga_usd_pkg::HdrLen - 1), 0, 1'b0,
					$urandom_range(0, 1), hold);
			end else if (pick < 92) begin
				case ($urandom_range(0, 2))
					0: w = 0;
					1: h = 0;
					default: begin
						do bpp = $urandom_range(0, 255);
						while (bpp == tga_usd_pkg::BppRgb || bpp == tga_usd_pkg::BppRgba);
					end
				endcase
				queue_file(w, h, bpp, -1, 0, 1'b0, 0, hold);
			end else if (pick < 96) begin
				queue_file($urandom_range(1, 65535), $urandom_range(1, 65535), bpp, -1,
					tga_usd_pkg::InfoEnd + $urandom_range(0, 12), 1'b1, 0, hold);
			end else begin
				repeat (4) queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
					$urandom_range(0, 3) == 0, 1'b0);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do @(negedge clk);
		while (byte_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
		repeat (20) @(negedge clk);

		if (err_cnt == 0)
			$display("tb_tga_uncompressed_stream_decoder_top: PASS");
		else
			$display("tb_tga_uncompressed_stream_decoder_top: FAIL");
		$finish;
	end

endmodule

@@ tga_uncompressed_stream_decoder_top.f @@
+incdir+rtl/core
rtl/core/tga_usd_pkg.sv
rtl/core/tga_usd_parse.sv
rtl/core/tga_usd_oreg.sv
rtl/core/tga_uncompressed_stream_decoder_top.sv
test/tb_tga_uncompressed_stream_decoder_top.sv
